// ===== rtl/tpw_pkg.sv =====
package tpw_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_XTAL_KHZ      = 3'd0;
  localparam logic [2:0] REG_CHIP_VARIANT  = 3'd1;
  localparam logic [2:0] REG_FLIP_CHIP     = 3'd2;
  localparam logic [2:0] REG_FM_VHF_EDGE   = 3'd3;
  localparam logic [2:0] REG_VHF_UHF_EDGE  = 3'd4;
  localparam logic [2:0] REG_UHF_LBAND_EDGE = 3'd5;
  localparam logic [2:0] REG_LBAND_SBAND_EDGE = 3'd6;

  // band codes
  localparam logic [2:0] BAND_FM    = 3'd0;
  localparam logic [2:0] BAND_TV_LO = 3'd1;
  localparam logic [2:0] BAND_TV_HI = 3'd2;
  localparam logic [2:0] BAND_L     = 3'd3;
  localparam logic [2:0] BAND_S     = 3'd4;

  // pipelined divider: one quotient bit per stage
  localparam int DIV_STAGES = 32;

  // reciprocals for division by constants
  localparam logic [16:0] RECIP_1K  = 17'd67109;   // 2^26 / 1000, rounded up
  localparam logic [16:0] RECIP_10K = 17'd107375;  // 2^30 / 10000, rounded up
  localparam logic [15:0] RECIP_10  = 16'd52429;   // 2^19 / 10, rounded up
  localparam logic [16:0] REF_ROUND = 17'd9999;

  localparam logic [31:0] LOOP_MARGIN = 32'd100;
  localparam logic [12:0] FRAC_SCALE  = 13'd6528;

  localparam logic [21:0] F_180M = 22'd180000;
  localparam logic [21:0] F_190M = 22'd190000;
  localparam logic [21:0] F_570M = 22'd570000;
  localparam logic [21:0] F_680M = 22'd680000;
  localparam logic [21:0] F_700M = 22'd700000;

  localparam logic [15:0] BSW_BASE = 16'h007b;
  localparam logic [15:0] LOC_UHF  = 16'h7c82;
  localparam logic [15:0] LOC_L    = 16'h7c84;
  localparam logic [15:0] LOC_OTH  = 16'h7c81;

  typedef struct packed {
    logic [15:0] xtal_khz;
    logic        chip_variant;
    logic        flip_chip;
    logic [21:0] fm_vhf_edge;
    logic [21:0] vhf_uhf_edge;
    logic [21:0] uhf_lband_edge;
    logic [21:0] lband_sband_edge;
  } tpw_cfg_t;

  // per-request data that rides along the pipeline
  typedef struct packed {
    logic [2:0]  band;
    logic [1:0]  bwc;
    logic        variant;
    logic        vco;
    logic [2:0]  hf;
    logic        ctrim;
    logic [7:0]  refdiv;
    logic [2:0]  tune;
    logic [1:0]  sw;
    logic [31:0] base;     // scaled VCO word or 2*f
    logic [15:0] fref;
    logic [12:0] fref10;
    logic [31:0] fbdiv;
  } tpw_side_t;

endpackage

// ===== rtl/tuner_pll_word_calculator.sv =====
// Tuner PLL word calculator.
// A request is taken at a clock edge where start is high and busy is low;
// busy stays low, so a request may be issued in every cycle. The request is
// in_freq_khz (kHz) and in_bandwidth_code.
// Each request gives one result word: out_valid is high for exactly one
// cycle, with all out_ fields valid in that cycle. Results leave in request
// order, one per cycle at most.
// The receiver cannot stall; it must take the word in its strobe cycle.
// The pipeline is three 32-stage restoring dividers in series (reference
// frequency, feedback divider, fraction) plus eight registered stages.
// Registers are written over the cfg_ channel (cfg_ready is always high). The user
// must write them only while no request is in flight; the block does not enforce
// this. An index beyond the list is ignored. Synchronous reset (rst_n low)
// restores register defaults and drops every request in flight; no result is given for those.
module tuner_pll_word_calculator
  import tpw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [21:0] in_freq_khz,
  input  logic [1:0]  in_bandwidth_code,
  output logic        out_valid,
  output logic [2:0]  out_band,
  output logic [15:0] out_lo4_word,
  output logic [15:0] out_feedback_divider,
  output logic [15:0] out_den_refdiv_word,
  output logic [15:0] out_fraction_numerator,
  output logic [15:0] out_band_switch_word,
  output logic [15:0] out_lo_control_word,
  output logic [15:0] out_lna_word,
  output logic [15:0] out_tune_word,
  output logic [1:0]  out_bandwidth_bits,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [21:0] cfg_data
);

  tpw_cfg_t    cfg_r;

  logic        fr_valid;
  tpw_side_t   fr_side;
  logic        da_valid;
  logic [31:0] da_quot;
  tpw_side_t   da_side;

  logic        s3_valid_r;
  tpw_side_t   s3_side_r;
  logic [31:0] s3_dvd_r;
  logic [15:0] s3_dvs_r;
  logic [15:0] fref;
  logic [31:0] fref_prod;
  tpw_side_t   s3_side_nxt;

  logic        db_valid;
  logic [31:0] db_quot;
  tpw_side_t   db_side;
  logic        rs_valid;
  logic [31:0] rs_dvd;
  logic [15:0] rs_dvs;
  tpw_side_t   rs_side;
  logic        dc_valid;
  logic [31:0] dc_quot;
  tpw_side_t   dc_side;
  logic        frac_on;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.xtal_khz         <= 16'd12000;
      cfg_r.chip_variant     <= 1'b0;
      cfg_r.flip_chip        <= 1'b0;
      cfg_r.fm_vhf_edge      <= 22'd115000;
      cfg_r.vhf_uhf_edge     <= 22'd250000;
      cfg_r.uhf_lband_edge   <= 22'd863000;
      cfg_r.lband_sband_edge <= 22'd2000000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_XTAL_KHZ:         cfg_r.xtal_khz         <= cfg_data[15:0];
        REG_CHIP_VARIANT:     cfg_r.chip_variant     <= cfg_data[0];
        REG_FLIP_CHIP:        cfg_r.flip_chip        <= cfg_data[0];
        REG_FM_VHF_EDGE:      cfg_r.fm_vhf_edge      <= cfg_data;
        REG_VHF_UHF_EDGE:     cfg_r.vhf_uhf_edge     <= cfg_data;
        REG_UHF_LBAND_EDGE:   cfg_r.uhf_lband_edge   <= cfg_data;
        REG_LBAND_SBAND_EDGE: cfg_r.lband_sband_edge <= cfg_data;
        default: ;
      endcase
    end
  end

  tpw_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_valid          (start && !busy),
    .in_freq_khz       (in_freq_khz),
    .in_bandwidth_code (in_bandwidth_code),
    .out_valid         (fr_valid),
    .out_side          (fr_side)
  );

  // reference frequency = crystal frequency (xtal_khz) / refdiv
  tpw_div u_div_ref (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (fr_valid),
    .in_dividend  ({16'b0, cfg_r.xtal_khz}),
    .in_divisor   ({8'b0, fr_side.refdiv}),
    .in_side      (fr_side),
    .out_valid    (da_valid),
    .out_quotient (da_quot),
    .out_side     (da_side)
  );

  // stage 3: fref, fref/10 and feedback divider operands
  always_comb begin
    fref              = da_quot[15:0];
    fref_prod         = fref * RECIP_10;
    s3_side_nxt       = da_side;
    s3_side_nxt.fref  = fref;
    s3_side_nxt.fref10 = fref_prod[31:19];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= da_valid;
    end
    s3_side_r <= s3_side_nxt;
    s3_dvd_r  <= da_side.variant ? da_side.base : (da_side.base >> 1);
    s3_dvs_r  <= da_side.variant ? fref : (fref >> 1);
  end

  tpw_div u_div_fb (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (s3_valid_r),
    .in_dividend  (s3_dvd_r),
    .in_divisor   (s3_dvs_r),
    .in_side      (s3_side_r),
    .out_valid    (db_valid),
    .out_quotient (db_quot),
    .out_side     (db_side)
  );

  tpw_rest u_rest (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (db_valid),
    .in_quotient  (db_quot),
    .in_side      (db_side),
    .out_valid    (rs_valid),
    .out_dividend (rs_dvd),
    .out_divisor  (rs_dvs),
    .out_side     (rs_side)
  );

  tpw_div u_div_frac (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (rs_valid),
    .in_dividend  (rs_dvd),
    .in_divisor   (rs_dvs),
    .in_side      (rs_side),
    .out_valid    (dc_valid),
    .out_quotient (dc_quot),
    .out_side     (dc_side)
  );

  // output stage: assemble the register words
  assign frac_on = (dc_quot != 32'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dc_valid;
    end
    out_band               <= dc_side.band;
    out_lo4_word           <= {1'b0, frac_on, 1'b0, frac_on, dc_side.vco, dc_side.ctrim,
                               dc_side.hf, 7'b0};
    out_feedback_divider   <= dc_side.fbdiv[15:0];
    out_den_refdiv_word    <= {frac_on ? 8'hff : 8'h01, dc_side.refdiv};
    out_fraction_numerator <= frac_on ? dc_quot[15:0] : 16'd0;
    if (dc_side.band == BAND_TV_HI) begin
      out_band_switch_word <= BSW_BASE | 16'h4800;
      out_lo_control_word  <= LOC_UHF;
    end else if (dc_side.band == BAND_L) begin
      out_band_switch_word <= BSW_BASE | 16'h2400;
      out_lo_control_word  <= LOC_L;
    end else begin
      out_band_switch_word <= BSW_BASE | 16'h9000;
      out_lo_control_word  <= LOC_OTH;
    end
    out_lna_word       <= {3'b000, dc_side.sw, 3'b111, 2'b00, dc_side.tune, 3'b011};
    out_tune_word      <= {3'b000, dc_side.tune, 1'b0, 2'b11, 7'h7f};
    out_bandwidth_bits <= dc_side.bwc;
  end

`ifndef NO_ASSERTIONS
  a_band_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_band <= BAND_S)
    else $error("band code out of range");
  a_den_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fraction_numerator != 16'd0) |-> out_den_refdiv_word[15:8] == 8'hff)
    else $error("fraction without fractional denominator");
  a_refdiv_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_den_refdiv_word[7:0] != 8'd0)
    else $error("zero reference divider");
`endif

endmodule

// ===== rtl/tpw_div.sv =====
module tpw_div
  import tpw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [31:0] in_dividend,
  input  logic [15:0] in_divisor,
  input  tpw_side_t   in_side,
  output logic        out_valid,
  output logic [31:0] out_quotient,
  output tpw_side_t   out_side
);

  logic        valid_r [DIV_STAGES];
  logic [15:0] rem_r   [DIV_STAGES];
  logic [31:0] acc_r   [DIV_STAGES];
  logic [15:0] dvs_r   [DIV_STAGES];
  tpw_side_t   side_r  [DIV_STAGES];

  logic        valid_nxt [DIV_STAGES];
  logic [15:0] rem_nxt   [DIV_STAGES];
  logic [31:0] acc_nxt   [DIV_STAGES];
  logic [15:0] dvs_nxt   [DIV_STAGES];
  tpw_side_t   side_nxt  [DIV_STAGES];
  logic [16:0] trial     [DIV_STAGES];
  logic [15:0] src_rem   [DIV_STAGES];
  logic [31:0] src_acc   [DIV_STAGES];

  // restoring division, dividend shifts out as quotient bits shift in
  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        valid_nxt[k] = in_valid;
        src_rem[k]   = 16'd0;
        src_acc[k]   = in_dividend;
        dvs_nxt[k]   = in_divisor;
        side_nxt[k]  = in_side;
      end else begin
        valid_nxt[k] = valid_r[k-1];
        src_rem[k]   = rem_r[k-1];
        src_acc[k]   = acc_r[k-1];
        dvs_nxt[k]   = dvs_r[k-1];
        side_nxt[k]  = side_r[k-1];
      end
      trial[k] = {src_rem[k], src_acc[k][31]};
      if (trial[k] >= {1'b0, dvs_nxt[k]}) begin
        rem_nxt[k] = 16'(trial[k] - {1'b0, dvs_nxt[k]});
        acc_nxt[k] = {src_acc[k][30:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[k][15:0];
        acc_nxt[k] = {src_acc[k][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else begin
        valid_r[k] <= valid_nxt[k];
      end
      rem_r[k]  <= rem_nxt[k];
      acc_r[k]  <= acc_nxt[k];
      dvs_r[k]  <= dvs_nxt[k];
      side_r[k] <= side_nxt[k];
    end
  end

  // a zero divisor gives a zero quotient
  assign out_valid    = valid_r[DIV_STAGES-1];
  assign out_quotient = (dvs_r[DIV_STAGES-1] == 16'd0) ? 32'd0 : acc_r[DIV_STAGES-1];
  assign out_side     = side_r[DIV_STAGES-1];

endmodule

// ===== rtl/tpw_front.sv =====
module tpw_front
  import tpw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  tpw_cfg_t    cfg,
  input  logic        in_valid,
  input  logic [21:0] in_freq_khz,
  input  logic [1:0]  in_bandwidth_code,
  output logic        out_valid,
  output tpw_side_t   out_side
);

  logic        s1_valid_r;
  logic [21:0] s1_f_r;
  logic [1:0]  s1_bwc_r;
  logic [2:0]  s1_band_r;
  logic [7:0]  s1_rd_fm_r;
  logic [7:0]  s1_rd_vhf_r;
  logic [7:0]  s1_rd_oth_r;

  logic [2:0]  band_nxt;
  logic [33:0] prod_vhf;
  logic [32:0] prod_fm;
  logic [32:0] prod_oth;

  logic        s2_valid_r;
  tpw_side_t   s2_side_r;
  tpw_side_t   side_nxt;
  logic [4:0]  mult;
  logic        presc6;
  logic [26:0] scaled;
  logic [7:0]  refdiv;

  // stage 1: band sort and reference divider candidates
  always_comb begin
    if (in_freq_khz <= cfg.fm_vhf_edge) begin
      band_nxt = BAND_FM;
    end else if (in_freq_khz <= cfg.vhf_uhf_edge) begin
      band_nxt = BAND_TV_LO;
    end else if (in_freq_khz <= cfg.uhf_lband_edge) begin
      band_nxt = BAND_TV_HI;
    end else if (in_freq_khz <= cfg.lband_sband_edge) begin
      band_nxt = BAND_L;
    end else begin
      band_nxt = BAND_S;
    end
    prod_vhf = ({1'b0, cfg.xtal_khz} + REF_ROUND) * RECIP_10K;
    prod_fm  = cfg.xtal_khz * RECIP_1K;
    prod_oth = cfg.xtal_khz * RECIP_10K;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
    end
    s1_f_r      <= in_freq_khz;
    s1_bwc_r    <= in_bandwidth_code;
    s1_band_r   <= band_nxt;
    s1_rd_fm_r  <= {1'b0, prod_fm[32:26]};
    s1_rd_vhf_r <= {4'b0, prod_vhf[33:30]};
    s1_rd_oth_r <= {5'b0, prod_oth[32:30]};
  end

  // stage 2: divider codes, loop multiplier, tune fields
  always_comb begin
    side_nxt = '0;
    mult     = 5'd0;
    presc6   = 1'b0;
    side_nxt.band    = s1_band_r;
    side_nxt.bwc     = s1_bwc_r;
    side_nxt.variant = cfg.chip_variant;

    if (cfg.chip_variant) begin
      if (s1_band_r == BAND_L) begin
        side_nxt.vco = 1'b1; side_nxt.hf = 3'd1; mult = 5'd2;
      end else if (s1_band_r == BAND_S) begin
        side_nxt.vco = 1'b0; side_nxt.hf = 3'd0; side_nxt.ctrim = 1'b1; mult = 5'd1;
      end else if (s1_f_r < F_570M) begin
        side_nxt.vco = 1'b1; side_nxt.hf = 3'd3; presc6 = 1'b1; mult = 5'd6;
      end else if (s1_f_r < F_680M) begin
        side_nxt.vco = 1'b0; side_nxt.hf = 3'd2; mult = 5'd4;
      end else begin
        side_nxt.vco = 1'b1; side_nxt.hf = 3'd2; mult = 5'd4;
      end
    end else begin
      if (s1_band_r == BAND_FM) begin
        side_nxt.vco = 1'b0; side_nxt.hf = 3'd7; mult = 5'd24;
      end else if (s1_band_r == BAND_L) begin
        side_nxt.vco = 1'b1; side_nxt.hf = 3'd0; mult = 5'd2;
      end else if (s1_band_r == BAND_TV_LO) begin
        if (s1_f_r < F_180M) begin
          side_nxt.vco = 1'b0; side_nxt.hf = 3'd3; mult = 5'd16;
        end else if (s1_f_r < F_190M) begin
          side_nxt.vco = 1'b1; side_nxt.hf = 3'd3; mult = 5'd16;
        end else begin
          side_nxt.vco = 1'b0; side_nxt.hf = 3'd6; mult = 5'd12;
        end
      end else if (s1_f_r < F_570M) begin
        side_nxt.vco = 1'b1; side_nxt.hf = 3'd5; mult = 5'd6;
      end else if (s1_f_r < F_700M) begin
        side_nxt.vco = 1'b0; side_nxt.hf = 3'd1; mult = 5'd4;
      end else begin
        side_nxt.vco = 1'b1; side_nxt.hf = 3'd1; mult = 5'd4;
      end
    end

    // VCO word over the prescaler; with prescaler 6 and multiplier 6 it is 2*f
    if (presc6) begin
      scaled = {4'b0, s1_f_r, 1'b0};
    end else begin
      scaled = mult * s1_f_r;
    end
    side_nxt.base = cfg.chip_variant ? {5'b0, scaled} : {9'b0, s1_f_r, 1'b0};

    // reference divider by band, never zero
    if (s1_band_r == BAND_TV_LO) begin
      refdiv = s1_rd_vhf_r;
    end else if (s1_band_r == BAND_FM) begin
      refdiv = s1_rd_fm_r;
    end else begin
      refdiv = s1_rd_oth_r;
    end
    side_nxt.refdiv = (refdiv == 8'd0) ? 8'd1 : refdiv;

    // LNA tune and switch
    case (s1_band_r)
      BAND_FM: begin
        side_nxt.tune = 3'd0; side_nxt.sw = 2'd1;
      end
      BAND_TV_LO: begin
        if (s1_f_r <= 22'd180000) side_nxt.tune = 3'd0;
        else if (s1_f_r <= 22'd188200) side_nxt.tune = 3'd1;
        else if (s1_f_r <= 22'd196400) side_nxt.tune = 3'd2;
        else side_nxt.tune = 3'd3;
        side_nxt.sw = 2'd1;
      end
      BAND_L: begin
        if (s1_f_r <= 22'd1500000) side_nxt.tune = 3'd0;
        else if (s1_f_r <= 22'd1600000) side_nxt.tune = 3'd1;
        else side_nxt.tune = 3'd3;
        side_nxt.sw = 2'd0;
      end
      BAND_S: begin
        side_nxt.tune = 3'd7; side_nxt.sw = 2'd0;
      end
      default: begin
        if (cfg.flip_chip) begin
          if (s1_f_r <= 22'd550000) side_nxt.tune = 3'd0;
          else if (s1_f_r <= 22'd590000) side_nxt.tune = 3'd1;
          else if (s1_f_r <= 22'd666000) side_nxt.tune = 3'd3;
          else side_nxt.tune = 3'd5;
        end else begin
          if (s1_f_r <= 22'd550000) side_nxt.tune = 3'd2;
          else if (s1_f_r <= 22'd650000) side_nxt.tune = 3'd3;
          else if (s1_f_r <= 22'd750000) side_nxt.tune = 3'd5;
          else if (s1_f_r <= 22'd850000) side_nxt.tune = 3'd6;
          else side_nxt.tune = 3'd7;
        end
        side_nxt.sw = 2'd2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_side_r <= side_nxt;
  end

  assign out_valid = s2_valid_r;
  assign out_side  = s2_side_r;

endmodule

// ===== rtl/tpw_rest.sv =====
module tpw_rest
  import tpw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [31:0] in_quotient,
  input  tpw_side_t   in_side,
  output logic        out_valid,
  output logic [31:0] out_dividend,
  output logic [15:0] out_divisor,
  output tpw_side_t   out_side
);

  logic        s4_valid_r, s5_valid_r, s6_valid_r, s7_valid_r;
  tpw_side_t   s4_side_r, s5_side_r, s6_side_r, s7_side_r;
  logic [31:0] s4_prod_r;
  logic [31:0] s5_rest_r;
  logic [31:0] s6_rest_r;
  logic [31:0] s7_scaled_r;

  logic [31:0] prod_nxt;
  logic [31:0] lim_hi;
  logic [31:0] lim_lo;
  logic [31:0] rest_nxt;
  tpw_side_t   s4_side_nxt;
  tpw_side_t   s6_side_nxt;

  // stage 4: quotient times reference, wrapping at 32 bits
  assign prod_nxt = 32'(in_quotient * {16'b0, in_side.fref});

  always_comb begin
    s4_side_nxt       = in_side;
    s4_side_nxt.fbdiv = in_quotient;
  end

  // stage 6: snap remainder near the reference step edges
  always_comb begin
    lim_hi      = {16'b0, s5_side_r.fref} - LOOP_MARGIN;
    lim_lo      = {16'b0, s5_side_r.fref} - (LOOP_MARGIN << 1);
    s6_side_nxt = s5_side_r;
    if (s5_rest_r < LOOP_MARGIN) begin
      rest_nxt = 32'd0;
    end else if (s5_rest_r < (LOOP_MARGIN << 1)) begin
      rest_nxt = LOOP_MARGIN << 1;
    end else if (s5_rest_r > lim_hi) begin
      rest_nxt = 32'd0;
      s6_side_nxt.fbdiv = s5_side_r.fbdiv + 32'd1;
    end else if (s5_rest_r > lim_lo) begin
      rest_nxt = lim_lo;
    end else begin
      rest_nxt = s5_rest_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
      s7_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= in_valid;
      s5_valid_r <= s4_valid_r;
      s6_valid_r <= s5_valid_r;
      s7_valid_r <= s6_valid_r;
    end
    s4_side_r       <= s4_side_nxt;
    s4_prod_r       <= prod_nxt;
    // stage 5: remainder
    s5_side_r       <= s4_side_r;
    s5_rest_r       <= s4_side_r.base - s4_prod_r;
    s6_side_r       <= s6_side_nxt;
    s6_rest_r       <= rest_nxt;
    // stage 7: scale for the fraction
    s7_side_r       <= s6_side_r;
    s7_scaled_r     <= 32'(s6_rest_r * {19'b0, FRAC_SCALE});
  end

  assign out_valid    = s7_valid_r;
  assign out_dividend = s7_scaled_r;
  assign out_divisor  = {3'b0, s7_side_r.fref10};
  assign out_side     = s7_side_r;

`ifndef NO_ASSERTIONS
  // a remainder inside the low margin is cleared
  a_snap_low: assert property (@(posedge clk) disable iff (!rst_n)
    (s5_valid_r && s5_rest_r < LOOP_MARGIN) |=> s6_rest_r == 32'd0)
    else $error("small remainder not cleared");
`endif

endmodule
